// ----- rtl/cdrb_pkg.sv -----
// ============================================================================
// cdrb_pkg: shared definitions for the coprocessor DMA register block
// Item kinds, register indexes, status bit positions, controller states and
// the command bundle between the controller and the datapath.
// ============================================================================
package cdrb_pkg;

  // Default address widths of local (SP) memory and main memory.
  localparam int unsigned LocalAddrBitsDef = 12;
  localparam int unsigned MainAddrBitsDef  = 24;

  // Input beat layout: reg_addr and write_value packed into whole bytes.
  localparam int unsigned InDataW = 40;
  localparam int unsigned InUserW = 2;

  // Fixed output fields apart from the two address fields.
  localparam int unsigned FixedOutBits = 59;

  // Length word: fields that survive a length write.
  localparam logic [31:0] LEN_MASK = 32'hFF8F_FFF8;

  // Status bits driven by the DMA engine.
  localparam int unsigned STATUS_BUSY_BIT = 2;
  localparam int unsigned STATUS_FULL_BIT = 3;
  localparam int unsigned StatusW         = 15;

  // Item kinds carried in tuser.
  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_READ    = 2'd1,
    KIND_ADVANCE = 2'd2
  } kind_e;

  // Register word indexes within the window.
  typedef enum logic [2:0] {
    REG_SP_ADDR   = 3'd0,
    REG_RAM_ADDR  = 3'd1,
    REG_RD_LEN    = 3'd2,
    REG_WR_LEN    = 3'd3,
    REG_STATUS    = 3'd4,
    REG_DMA_FULL  = 3'd5,
    REG_DMA_BUSY  = 3'd6,
    REG_SEMAPHORE = 3'd7
  } reg_idx_e;

  // Interrupt change requests.
  typedef enum logic [1:0] {
    INTR_NONE  = 2'd0,
    INTR_RAISE = 2'd1,
    INTR_CLEAR = 2'd2
  } intr_e;

  // Controller sequence for one item.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_SCALE,
    ST_OUT
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
    logic multiply;
    logic scale;
  } ctrl_cmd_t;

endpackage

// ----- rtl/cdrb_ctrl.sv -----
// ============================================================================
// cdrb_ctrl: item sequencer
// Accepts one input beat, steps the datapath through execute, multiply and
// scale, then presents the result beat until it is taken.
// ============================================================================
module cdrb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cdrb_pkg::ctrl_cmd_t cmd_o
);
  import cdrb_pkg::*;

  ctrl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC:  state_d = ST_MUL;
      ST_MUL:   state_d = ST_SCALE;
      ST_SCALE: state_d = ST_OUT;
      ST_OUT: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    in_ready_o     = (state_q == ST_IDLE);
    out_valid_o    = (state_q == ST_OUT);
    cmd_o.capture  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.execute  = (state_q == ST_EXEC);
    cmd_o.multiply = (state_q == ST_MUL);
    cmd_o.scale    = (state_q == ST_SCALE);
  end

  // An accepted beat always comes out as a result after the full sequence.
  a_accept_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> ##4 out_valid_o)
    else $error("accepted beat did not reach the output stage");

endmodule

// ----- rtl/cdrb_datapath.sv -----
// ============================================================================
// cdrb_datapath: register file and strided DMA engine
// Holds the mirrored registers, the staged and active transfer and the beat
// cursors, and forms one result per item under controller commands.
// ============================================================================
module cdrb_datapath #(
  parameter int unsigned LOCAL_ADDR_BITS = cdrb_pkg::LocalAddrBitsDef,
  parameter int unsigned MAIN_ADDR_BITS  = cdrb_pkg::MainAddrBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cdrb_pkg::ctrl_cmd_t        cmd_i,
  input  logic [1:0]                 in_kind_i,
  input  logic [4:0]                 in_reg_addr_i,
  input  logic [31:0]                in_write_value_i,
  output logic [31:0]                read_data_o,
  output logic                       beat_valid_o,
  output logic                       beat_to_main_o,
  output logic                       beat_instr_bank_o,
  output logic [MAIN_ADDR_BITS-1:0]  beat_main_addr_o,
  output logic [LOCAL_ADDR_BITS-1:0] beat_local_addr_o,
  output logic                       dma_started_o,
  output logic [18:0]                dma_cycles_o,
  output logic                       dma_finished_o,
  output logic                       task_start_req_o,
  output logic [1:0]                 intr_change_o
);
  import cdrb_pkg::*;

  localparam int unsigned LW  = LOCAL_ADDR_BITS;
  localparam int unsigned LW1 = LOCAL_ADDR_BITS + 1;
  localparam int unsigned MW  = MAIN_ADDR_BITS;

  // Set wins over keep, clear wins over keep, both together keep.
  function automatic logic set_clr(input logic cur, input logic s, input logic c);
    set_clr = (s ^ c) ? s : cur;
  endfunction

  // Captured input beat.
  logic [1:0]  kind_q;
  logic [4:0]  reg_addr_q;
  logic [31:0] value_q;

  // Architectural state.
  logic [StatusW-1:0] status_q, status_d;
  logic               full_q, full_d;
  logic               busy_q, busy_d;
  logic               sem_q, sem_d;
  logic [LW1-1:0]     act_local_q, act_local_d;
  logic [MW-1:0]      act_main_q, act_main_d;
  logic [31:0]        rd_len_q, rd_len_d;
  logic [31:0]        wr_len_q, wr_len_d;
  logic [LW1-1:0]     stg_local_q, stg_local_d;
  logic [MW-1:0]      stg_main_q, stg_main_d;
  logic [31:0]        stg_len_q, stg_len_d;
  logic               stg_to_main_q, stg_to_main_d;
  logic               act_to_main_q, act_to_main_d;
  logic signed [12:0] beat_rem_q, beat_rem_d;
  logic [11:0]        row_len_q, row_len_d;
  logic [8:0]         rows_left_q, rows_left_d;
  logic [11:0]        row_skip_q, row_skip_d;
  logic [MW-1:0]      cur_main_q, cur_main_d;
  logic [LW-1:0]      cur_local_q, cur_local_d;

  // Result registers.
  logic [31:0]   read_data_q, read_data_d;
  logic          beat_valid_q, beat_valid_d;
  logic          beat_to_main_q, beat_to_main_d;
  logic          beat_bank_q, beat_bank_d;
  logic [MW-1:0] beat_main_q, beat_main_d;
  logic [LW-1:0] beat_local_q, beat_local_d;
  logic          started_q, started_d;
  logic          finished_q, finished_d;
  logic          task_q, task_d;
  logic [1:0]    intr_q, intr_d;
  logic [20:0]   prod_q;
  logic [18:0]   cycles_q;

  // Helpers.
  logic [2:0]         idx;
  logic [31:0]        act_local_ext;
  logic signed [12:0] beat_rem_dec;
  logic [11:0]        launch_len;
  logic [8:0]         launch_cnt;
  logic [17:0]        prod_div8;
  logic               do_load;
  logic               do_finish;

  assign idx           = reg_addr_q[4:2];
  assign act_local_ext = 32'(act_local_q);
  assign beat_rem_dec  = beat_rem_q - 13'sd8;

  // Row length and row count of the staged length word.
  assign launch_len = stg_len_q[11:0] | 12'h007;
  assign launch_cnt = {1'b0, stg_len_q[19:12]} + 9'd1;
  assign prod_div8  = prod_q[20:3];

  // Execution of one item.
  always_comb begin
    status_d      = status_q;
    full_d        = full_q;
    busy_d        = busy_q;
    sem_d         = sem_q;
    act_local_d   = act_local_q;
    act_main_d    = act_main_q;
    rd_len_d      = rd_len_q;
    wr_len_d      = wr_len_q;
    stg_local_d   = stg_local_q;
    stg_main_d    = stg_main_q;
    stg_len_d     = stg_len_q;
    stg_to_main_d = stg_to_main_q;
    act_to_main_d = act_to_main_q;
    beat_rem_d    = beat_rem_q;
    row_len_d     = row_len_q;
    rows_left_d   = rows_left_q;
    row_skip_d    = row_skip_q;
    cur_main_d    = cur_main_q;
    cur_local_d   = cur_local_q;

    read_data_d    = '0;
    beat_valid_d   = 1'b0;
    beat_to_main_d = 1'b0;
    beat_bank_d    = 1'b0;
    beat_main_d    = '0;
    beat_local_d   = '0;
    started_d      = 1'b0;
    finished_d     = 1'b0;
    task_d         = 1'b0;
    intr_d         = INTR_NONE;
    do_load        = 1'b0;
    do_finish      = 1'b0;

    unique case (kind_e'(kind_q))
      KIND_WRITE: begin
        unique case (reg_idx_e'(idx))
          REG_SP_ADDR:  stg_local_d = value_q[LW1-1:0] & ~LW1'(7);
          REG_RAM_ADDR: stg_main_d  = value_q[MW-1:0] & ~MW'(7);
          REG_RD_LEN, REG_WR_LEN: begin
            if (!full_q) begin
              stg_len_d     = value_q & LEN_MASK;
              stg_to_main_d = (reg_idx_e'(idx) == REG_WR_LEN);
              if (busy_q) begin
                full_d                   = 1'b1;
                status_d[STATUS_FULL_BIT] = 1'b1;
              end
            end
            if (!busy_q) do_load = 1'b1;
          end
          REG_STATUS: begin
            if (value_q[0]) task_d = 1'b1;
            for (int i = 0; i < 8; i++) begin
              status_d[7+i] = set_clr(status_q[7+i], value_q[10+2*i], value_q[9+2*i]);
            end
            status_d[6] = set_clr(status_q[6], value_q[8], value_q[7]);
            status_d[5] = set_clr(status_q[5], value_q[6], value_q[5]);
            if (value_q[3]) begin
              intr_d = INTR_CLEAR;
            end else if (value_q[4]) begin
              intr_d = INTR_RAISE;
            end
            if (value_q[2]) status_d[1] = 1'b0;
            status_d[0] = set_clr(status_q[0], value_q[1], value_q[0]);
          end
          REG_SEMAPHORE: sem_d = value_q[0];
          default: ;
        endcase
      end
      KIND_READ: begin
        unique case (reg_idx_e'(idx))
          REG_SP_ADDR:  read_data_d = act_local_ext;
          REG_RAM_ADDR: read_data_d = 32'(act_main_q);
          REG_RD_LEN:   read_data_d = rd_len_q;
          REG_WR_LEN:   read_data_d = wr_len_q;
          REG_STATUS:   read_data_d = 32'(status_q);
          REG_DMA_FULL: read_data_d = 32'(full_q);
          REG_DMA_BUSY: read_data_d = 32'(busy_q);
          default:      read_data_d = 32'(sem_q);
        endcase
      end
      KIND_ADVANCE: begin
        if (busy_q) begin
          if (rows_left_q == 9'd0) begin
            do_finish = 1'b1;
          end else begin
            // One beat at the current cursors.
            beat_valid_d   = 1'b1;
            beat_to_main_d = act_to_main_q;
            beat_bank_d    = act_local_ext[12];
            beat_main_d    = cur_main_q;
            beat_local_d   = cur_local_q;
            beat_rem_d     = beat_rem_dec;
            cur_main_d     = cur_main_q + MW'(8);
            cur_local_d    = cur_local_q + LW'(8);
            rd_len_d       = {row_skip_q, 20'd0} | {11'd0, rows_left_q, 12'd0}
                             | {20'd0, beat_rem_dec[11:3], 3'd0};
            wr_len_d       = rd_len_d;
            // End of a row: step to the next one past the skip.
            if (beat_rem_dec[12]) begin
              rows_left_d = rows_left_q - 9'd1;
              beat_rem_d  = $signed({1'b0, row_len_q});
              cur_main_d  = cur_main_q + MW'(8) + MW'(row_skip_q);
              if (rows_left_d == 9'd0) do_finish = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase

    // Completion: launch the queued transfer or go idle.
    if (do_finish) begin
      finished_d = 1'b1;
      if (full_q) begin
        do_load                   = 1'b1;
        full_d                    = 1'b0;
        status_d[STATUS_FULL_BIT] = 1'b0;
      end else begin
        busy_d                    = 1'b0;
        status_d[STATUS_BUSY_BIT] = 1'b0;
      end
    end

    // Launch from the staged registers.
    if (do_load) begin
      act_local_d               = stg_local_d;
      act_main_d                = stg_main_d;
      rd_len_d                  = stg_len_d;
      wr_len_d                  = stg_len_d;
      act_to_main_d             = stg_to_main_d;
      busy_d                    = 1'b1;
      status_d[STATUS_BUSY_BIT] = 1'b1;
      cur_main_d                = stg_main_d;
      cur_local_d               = stg_local_d[LW-1:0];
      row_len_d                 = stg_len_d[11:0] | 12'h007;
      beat_rem_d                = $signed({1'b0, row_len_d});
      rows_left_d               = {1'b0, stg_len_d[19:12]} + 9'd1;
      row_skip_d                = {stg_len_d[31:23], 3'd0};
      started_d                 = 1'b1;
    end
  end

  // Architectural state, updated once per item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q      <= '0;
      full_q        <= 1'b0;
      busy_q        <= 1'b0;
      sem_q         <= 1'b0;
      act_local_q   <= '0;
      act_main_q    <= '0;
      rd_len_q      <= '0;
      wr_len_q      <= '0;
      stg_local_q   <= '0;
      stg_main_q    <= '0;
      stg_len_q     <= '0;
      stg_to_main_q <= 1'b0;
      act_to_main_q <= 1'b0;
      beat_rem_q    <= '0;
      row_len_q     <= '0;
      rows_left_q   <= '0;
      row_skip_q    <= '0;
      cur_main_q    <= '0;
      cur_local_q   <= '0;
    end else if (cmd_i.execute) begin
      status_q      <= status_d;
      full_q        <= full_d;
      busy_q        <= busy_d;
      sem_q         <= sem_d;
      act_local_q   <= act_local_d;
      act_main_q    <= act_main_d;
      rd_len_q      <= rd_len_d;
      wr_len_q      <= wr_len_d;
      stg_local_q   <= stg_local_d;
      stg_main_q    <= stg_main_d;
      stg_len_q     <= stg_len_d;
      stg_to_main_q <= stg_to_main_d;
      act_to_main_q <= act_to_main_d;
      beat_rem_q    <= beat_rem_d;
      row_len_q     <= row_len_d;
      rows_left_q   <= rows_left_d;
      row_skip_q    <= row_skip_d;
      cur_main_q    <= cur_main_d;
      cur_local_q   <= cur_local_d;
    end
  end

  // Input capture, result registers and the launch duration pipeline.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q     <= in_kind_i;
      reg_addr_q <= in_reg_addr_i;
      value_q    <= in_write_value_i;
    end
    if (cmd_i.execute) begin
      read_data_q    <= read_data_d;
      beat_valid_q   <= beat_valid_d;
      beat_to_main_q <= beat_to_main_d;
      beat_bank_q    <= beat_bank_d;
      beat_main_q    <= beat_main_d;
      beat_local_q   <= beat_local_d;
      started_q      <= started_d;
      finished_q     <= finished_d;
      task_q         <= task_d;
      intr_q         <= intr_d;
    end
    // Row length times row count of the transfer just launched.
    if (cmd_i.multiply) begin
      prod_q <= launch_len * launch_cnt;
    end
    // Divide by eight, times three, by shift and add.
    if (cmd_i.scale) begin
      cycles_q <= started_q ? 19'(prod_div8) + {prod_div8, 1'b0} : 19'd0;
    end
  end

  assign read_data_o       = read_data_q;
  assign beat_valid_o      = beat_valid_q;
  assign beat_to_main_o    = beat_to_main_q;
  assign beat_instr_bank_o = beat_bank_q;
  assign beat_main_addr_o  = beat_main_q;
  assign beat_local_addr_o = beat_local_q;
  assign dma_started_o     = started_q;
  assign dma_cycles_o      = cycles_q;
  assign dma_finished_o    = finished_q;
  assign task_start_req_o  = task_q;
  assign intr_change_o     = intr_q;

  // A queued transfer exists only behind a running one.
  a_full_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |-> busy_q)
    else $error("DMA full flag set while not busy");

  // The status word mirrors the busy and full flags.
  a_status_mirror: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status_q[STATUS_BUSY_BIT] == busy_q) && (status_q[STATUS_FULL_BIT] == full_q))
    else $error("status busy/full bits out of step with the flags");

  // A running transfer always has at least one row to move.
  a_busy_has_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rows_left_q != 9'd0))
    else $error("busy transfer with no rows left");

endmodule

// ----- rtl/coprocessor_dma_register_block_unit.sv -----
// ============================================================================
// coprocessor_dma_register_block_unit: coprocessor registers with strided DMA
// Stream wrapper around the item sequencer and the register/DMA datapath.
// ============================================================================
// Each input beat is one register write, one register read or one DMA beat
// advance, and gives exactly one result beat. The block handles one item at
// a time: after accepting a beat it steps through execute, launch-duration
// multiply and scale, then presents the result beat until m_axis_tready
// takes it, and only after that takes the next input beat. The multiply of
// row length by row count and its scaling to a cycle estimate are the two
// registered steps that follow execute; all register and cursor updates
// happen in the single execute cycle.
module coprocessor_dma_register_block_unit #(
  parameter int unsigned LOCAL_ADDR_BITS = cdrb_pkg::LocalAddrBitsDef,
  parameter int unsigned MAIN_ADDR_BITS  = cdrb_pkg::MainAddrBitsDef,
  localparam int unsigned OutBits = cdrb_pkg::FixedOutBits + LOCAL_ADDR_BITS
                                    + MAIN_ADDR_BITS,
  localparam int unsigned OutW    = ((OutBits + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // reg_addr[4:0], write_value[36:5], zero fill
  input  logic [cdrb_pkg::InDataW-1:0]  s_axis_tdata,
  // kind[1:0]
  input  logic [cdrb_pkg::InUserW-1:0]  s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // read_data[31:0], beat_valid, beat_to_main, beat_instr_bank,
  // beat_main_addr, beat_local_addr, dma_started, dma_cycles[18:0],
  // dma_finished, task_start_req, intr_change[1:0], zero fill
  output logic [OutW-1:0]               m_axis_tdata
);
  import cdrb_pkg::*;

  ctrl_cmd_t cmd;

  logic [31:0]                read_data;
  logic                       beat_valid;
  logic                       beat_to_main;
  logic                       beat_instr_bank;
  logic [MAIN_ADDR_BITS-1:0]  beat_main_addr;
  logic [LOCAL_ADDR_BITS-1:0] beat_local_addr;
  logic                       dma_started;
  logic [18:0]                dma_cycles;
  logic                       dma_finished;
  logic                       task_start_req;
  logic [1:0]                 intr_change;

  // Item sequencer.
  cdrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  // Registers and DMA engine.
  cdrb_datapath #(
    .LOCAL_ADDR_BITS (LOCAL_ADDR_BITS),
    .MAIN_ADDR_BITS  (MAIN_ADDR_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .in_kind_i         (s_axis_tuser[1:0]),
    .in_reg_addr_i     (s_axis_tdata[4:0]),
    .in_write_value_i  (s_axis_tdata[36:5]),
    .read_data_o       (read_data),
    .beat_valid_o      (beat_valid),
    .beat_to_main_o    (beat_to_main),
    .beat_instr_bank_o (beat_instr_bank),
    .beat_main_addr_o  (beat_main_addr),
    .beat_local_addr_o (beat_local_addr),
    .dma_started_o     (dma_started),
    .dma_cycles_o      (dma_cycles),
    .dma_finished_o    (dma_finished),
    .task_start_req_o  (task_start_req),
    .intr_change_o     (intr_change)
  );

  // Pack the result beat, first field in the lowest bits.
  assign m_axis_tdata = OutW'({intr_change, task_start_req, dma_finished, dma_cycles,
                               dma_started, beat_local_addr, beat_main_addr,
                               beat_instr_bank, beat_to_main, beat_valid, read_data});

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the coprocessor DMA register block
// Streams register writes, reads and DMA beat advances into the block and
// checks every result beat against a cycle-free prediction of the register
// file and the strided transfer engine, with random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import cdrb_pkg::*;

  localparam int unsigned RespW      = ((FixedOutBits + LocalAddrBitsDef + MainAddrBitsDef
                                         + 7) / 8) * 8;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned RandomItems = 1500;
  localparam int unsigned DrainCycles = 20;
  // Kind code that the block does not decode.
  localparam logic [1:0]  KindUnused = 2'd3;

  // One register access or beat advance.
  typedef struct {
    logic [1:0]  kind;
    logic [4:0]  reg_addr;
    logic [31:0] write_value;
  } access_t;

  // One result beat, field by field.
  typedef struct {
    logic [31:0] read_data;
    logic        beat_valid;
    logic        beat_to_main;
    logic        beat_instr_bank;
    logic [23:0] beat_main_addr;
    logic [11:0] beat_local_addr;
    logic        dma_started;
    logic [18:0] dma_cycles;
    logic        dma_finished;
    logic        task_start_req;
    logic [1:0]  intr_change;
  } dma_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  // reg_addr[4:0], write_value[36:5], zero fill
  logic [InDataW-1:0] s_axis_tdata = '0;
  // kind[1:0]
  logic [InUserW-1:0] s_axis_tuser = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  // read_data[31:0], beat_valid, beat_to_main, beat_instr_bank,
  // beat_main_addr[23:0], beat_local_addr[11:0], dma_started,
  // dma_cycles[18:0], dma_finished, task_start_req, intr_change[1:0], zero fill
  logic [RespW-1:0] m_axis_tdata;

  coprocessor_dma_register_block_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  access_t     queued_accesses[$];
  dma_result_t predicted_responses[$];
  int unsigned error_count = 0;
  int unsigned accepted_count = 0;
  int unsigned beats_moved = 0;
  int unsigned transfers_launched = 0;
  int unsigned transfers_done = 0;

  // --------------------------------------------------------------------------
  // Predicted register file and DMA engine state
  // --------------------------------------------------------------------------
  logic [14:0] status_q;
  logic        full_q, busy_q, sem_q;
  logic [12:0] act_local_q, stg_local_q;
  logic [23:0] act_main_q, stg_main_q;
  logic [31:0] rd_len_q, wr_len_q, stg_len_q;
  logic        stg_to_main_q, act_to_main_q;
  int          remaining_q;
  logic [11:0] row_len_q, skip_q, cur_local_q;
  logic [8:0]  rows_q;
  logic [23:0] cur_main_q;
  dma_result_t pred_out;

  // Set up the row walk of the transfer held in the length register.
  function automatic void launch_transfer();
    int unsigned len, cnt;
    len = int'(rd_len_q[11:0] | 12'h007);
    cnt = int'(rd_len_q[19:12]) + 1;
    cur_main_q  = act_main_q & 24'hFF_FFF8;
    cur_local_q = act_local_q[11:0] & 12'hFF8;
    remaining_q = int'(len);
    row_len_q   = 12'(len);
    rows_q      = 9'(cnt);
    skip_q      = rd_len_q[31:20] & 12'hFF8;
    pred_out.dma_started = 1'b1;
    pred_out.dma_cycles  = 19'(len * cnt / 8 * 3);
    transfers_launched++;
  endfunction

  // Move the staged transfer into the active registers and start it.
  function automatic void load_staged();
    act_local_q   = stg_local_q;
    act_main_q    = stg_main_q;
    rd_len_q      = stg_len_q;
    wr_len_q      = stg_len_q;
    act_to_main_q = stg_to_main_q;
    busy_q        = 1'b1;
    status_q[STATUS_BUSY_BIT] = 1'b1;
    launch_transfer();
  endfunction

  // The active transfer is done; a queued one takes its place.
  function automatic void end_transfer();
    pred_out.dma_finished = 1'b1;
    transfers_done++;
    if (full_q) begin
      load_staged();
      full_q = 1'b0;
      status_q[STATUS_FULL_BIT] = 1'b0;
    end else begin
      busy_q = 1'b0;
      status_q[STATUS_BUSY_BIT] = 1'b0;
    end
  endfunction

  // A status bit with both its set and clear bits on keeps its value.
  function automatic void set_or_clear(logic [31:0] v, int sbit, int cbit, int pos);
    if (v[sbit] && v[cbit]) return;
    if (v[sbit]) status_q[pos] = 1'b1;
    if (v[cbit]) status_q[pos] = 1'b0;
  endfunction

  function automatic void write_status(logic [31:0] v);
    if (v[0]) pred_out.task_start_req = 1'b1;
    for (int i = 0; i < 8; i++) set_or_clear(v, 10 + 2 * i, 9 + 2 * i, 7 + i);
    set_or_clear(v, 8, 7, 6);
    set_or_clear(v, 6, 5, 5);
    // Clear wins over raise when both are asked for.
    if (v[4]) pred_out.intr_change = INTR_RAISE;
    if (v[3]) pred_out.intr_change = INTR_CLEAR;
    if (v[2]) status_q[1] = 1'b0;
    set_or_clear(v, 1, 0, 0);
  endfunction

  function automatic void write_register(reg_idx_e idx, logic [31:0] v);
    case (idx)
      REG_SP_ADDR:  stg_local_q = v[12:0] & 13'h1FF8;
      REG_RAM_ADDR: stg_main_q  = v[23:0] & 24'hFF_FFF8;
      REG_RD_LEN, REG_WR_LEN: begin
        // A length write while a transfer is queued leaves staging alone.
        if (!full_q) begin
          stg_len_q     = v & LEN_MASK;
          stg_to_main_q = (idx == REG_WR_LEN);
          if (busy_q) begin
            full_q = 1'b1;
            status_q[STATUS_FULL_BIT] = 1'b1;
          end
        end
        if (!busy_q) load_staged();
      end
      REG_STATUS:    write_status(v);
      REG_SEMAPHORE: sem_q = v[0];
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] read_register(reg_idx_e idx);
    case (idx)
      REG_SP_ADDR:  return {19'd0, act_local_q};
      REG_RAM_ADDR: return {8'd0, act_main_q};
      REG_RD_LEN:   return rd_len_q;
      REG_WR_LEN:   return wr_len_q;
      REG_STATUS:   return {17'd0, status_q};
      REG_DMA_FULL: return {31'd0, full_q};
      REG_DMA_BUSY: return {31'd0, busy_q};
      default:      return {31'd0, sem_q};
    endcase
  endfunction

  // One 8-byte beat of the strided walk, with length write-back.
  function automatic void advance_beat();
    logic [31:0] len_word;
    if (!busy_q) return;
    if (rows_q == 9'd0) begin
      end_transfer();
      return;
    end
    pred_out.beat_valid      = 1'b1;
    pred_out.beat_to_main    = act_to_main_q;
    pred_out.beat_instr_bank = act_local_q[12];
    pred_out.beat_main_addr  = cur_main_q;
    pred_out.beat_local_addr = cur_local_q;
    beats_moved++;
    remaining_q -= 8;
    cur_main_q  += 24'd8;
    cur_local_q += 12'd8;
    len_word = {skip_q, 20'd0} | (32'(rows_q) << 12) | (32'(remaining_q) & 32'hFF8);
    rd_len_q = len_word;
    wr_len_q = len_word;
    if (remaining_q < 0) begin
      rows_q      = rows_q - 9'd1;
      remaining_q = int'(row_len_q);
      cur_main_q  = cur_main_q + {12'd0, skip_q};
      if (rows_q == 9'd0) end_transfer();
    end
  endfunction

  function automatic dma_result_t predict_access(access_t a);
    reg_idx_e idx;
    idx = reg_idx_e'(a.reg_addr[4:2]);
    pred_out = '{default: '0};
    case (a.kind)
      KIND_WRITE:   write_register(idx, a.write_value);
      KIND_READ:    pred_out.read_data = read_register(idx);
      KIND_ADVANCE: advance_beat();
      default: ;
    endcase
    return pred_out;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void add_access(logic [1:0] kind, reg_idx_e idx, logic [1:0] low,
                                     logic [31:0] value);
    access_t a;
    a.kind        = kind;
    a.reg_addr    = {idx, low};
    a.write_value = value;
    queued_accesses.push_back(a);
  endfunction

  // Length words are kept short so that transfers finish within the run.
  function automatic logic [31:0] pick_length();
    int unsigned sel, rows, len;
    sel  = $urandom_range(0, 99);
    rows = $urandom_range(0, 3);
    len  = $urandom_range(0, 63);
    if (sel < 4) begin
      rows = 0;
      len  = $urandom_range(0, 4095);
    end else if (sel < 10) begin
      rows = $urandom_range(0, 31);
    end else if (sel == 10) begin
      rows = 255;
      len  = $urandom_range(0, 7);
    end
    return ($urandom & 32'hFFF0_0000) | (rows << 12) | len;
  endfunction

  // Mostly short pauses, now and then a long one.
  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers queued accesses one beat at a time
  // --------------------------------------------------------------------------
  access_t     in_flight;
  int unsigned gap_left = 0;
  bit          tx_steady = 1'b0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predicted_responses.push_back(predict_access(in_flight));
        accepted_count++;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // Beat still waiting: hold it.
      end else if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (queued_accesses.size() != 0) begin
        in_flight = queued_accesses.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'd0, in_flight.write_value, in_flight.reg_addr};
        s_axis_tuser  <= in_flight.kind;
        if ($urandom_range(0, 99) == 0) tx_steady = !tx_steady;
        gap_left = tx_steady ? 0 : pick_pause();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: takes result beats with random stalls and checks them
  // --------------------------------------------------------------------------
  int unsigned stall_left = 0;
  bit          rx_steady = 1'b0;

  task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    dma_result_t exp;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (predicted_responses.size() == 0) begin
          $error("result beat with no access outstanding");
          error_count++;
        end else begin
          exp = predicted_responses.pop_front();
          check_field("read_data", exp.read_data, m_axis_tdata[31:0]);
          check_field("beat_valid", 32'(exp.beat_valid), 32'(m_axis_tdata[32]));
          check_field("beat_to_main", 32'(exp.beat_to_main), 32'(m_axis_tdata[33]));
          check_field("beat_instr_bank", 32'(exp.beat_instr_bank), 32'(m_axis_tdata[34]));
          check_field("beat_main_addr", 32'(exp.beat_main_addr), 32'(m_axis_tdata[58:35]));
          check_field("beat_local_addr", 32'(exp.beat_local_addr),
                      32'(m_axis_tdata[70:59]));
          check_field("dma_started", 32'(exp.dma_started), 32'(m_axis_tdata[71]));
          check_field("dma_cycles", 32'(exp.dma_cycles), 32'(m_axis_tdata[90:72]));
          check_field("dma_finished", 32'(exp.dma_finished), 32'(m_axis_tdata[91]));
          check_field("task_start_req", 32'(exp.task_start_req), 32'(m_axis_tdata[92]));
          check_field("intr_change", 32'(exp.intr_change), 32'(m_axis_tdata[94:93]));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 99) == 0) rx_steady = !rx_steady;
        stall_left = rx_steady ? 0 : pick_pause();
      end
    end
  end

  // Run limit.
  int unsigned cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, predicted_responses.size());
      $display("testbench: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int unsigned sel;
    access_t     a;

    status_q = '0; full_q = 1'b0; busy_q = 1'b0; sem_q = 1'b0;
    act_local_q = '0; stg_local_q = '0; act_main_q = '0; stg_main_q = '0;
    rd_len_q = '0; wr_len_q = '0; stg_len_q = '0;
    stg_to_main_q = 1'b0; act_to_main_q = 1'b0;
    remaining_q = 0; row_len_q = '0; skip_q = '0; cur_local_q = '0;
    rows_q = '0; cur_main_q = '0;

    // Idle advance, an undecoded kind and a status read straight after reset.
    add_access(KIND_ADVANCE, REG_SP_ADDR, 2'd0, 32'd0);
    add_access(KindUnused, REG_SEMAPHORE, 2'd3, 32'hFFFF_FFFF);
    add_access(KIND_READ, REG_STATUS, 2'd0, 32'd0);
    // Highest addresses, so both cursors wrap; two rows with the largest skip.
    add_access(KIND_WRITE, REG_SP_ADDR, 2'd3, 32'hFFFF_FFFF);
    add_access(KIND_WRITE, REG_RAM_ADDR, 2'd0, 32'hFFFF_FFFF);
    add_access(KIND_WRITE, REG_WR_LEN, 2'd0, 32'hFF80_1008);
    // Queue a second transfer, then try a length write while the queue is full.
    add_access(KIND_WRITE, REG_RD_LEN, 2'd1, 32'd0);
    add_access(KIND_WRITE, REG_RD_LEN, 2'd2, 32'hFFFF_FFFF);
    add_access(KIND_READ, REG_DMA_FULL, 2'd0, 32'd0);
    // The flag registers are read-only.
    add_access(KIND_WRITE, REG_DMA_BUSY, 2'd0, 32'hFFFF_FFFF);
    add_access(KIND_WRITE, REG_DMA_FULL, 2'd1, 32'hFFFF_FFFF);
    // Walk the first transfer; its last beat starts the queued one.
    repeat (4) add_access(KIND_ADVANCE, REG_SP_ADDR, 2'd0, 32'd0);
    add_access(KIND_READ, REG_RD_LEN, 2'd1, 32'd0);
    add_access(KIND_ADVANCE, REG_SP_ADDR, 2'd0, 32'd0);
    // Status: every set bit, every clear bit, then both together.
    add_access(KIND_WRITE, REG_STATUS, 2'd0, 32'h0155_5552);
    add_access(KIND_READ, REG_STATUS, 2'd2, 32'd0);
    add_access(KIND_WRITE, REG_STATUS, 2'd1, 32'h00AA_AAA9);
    add_access(KIND_WRITE, REG_STATUS, 2'd3, 32'hFFFF_FFFF);
    add_access(KIND_READ, REG_STATUS, 2'd0, 32'd0);
    add_access(KIND_WRITE, REG_SEMAPHORE, 2'd3, 32'hFFFF_FFFF);
    add_access(KIND_READ, REG_SEMAPHORE, 2'd0, 32'd0);
    add_access(KIND_WRITE, REG_SEMAPHORE, 2'd2, 32'd0);

    // Random mix, weighted toward length writes and beat advances so that
    // transfers launch, queue and complete throughout the run.
    for (int unsigned n = 0; n < RandomItems; n++) begin
      sel = $urandom_range(0, 99);
      a.reg_addr    = 5'($urandom_range(0, 31));
      a.write_value = $urandom;
      if (sel < 38) begin
        a.kind = KIND_ADVANCE;
      end else if (sel < 58) begin
        a.kind = KIND_READ;
      end else if (sel < 96) begin
        a.kind = KIND_WRITE;
        if ($urandom_range(0, 9) < 4) begin
          a.reg_addr[4:2] = $urandom_range(0, 1) ? REG_WR_LEN : REG_RD_LEN;
        end
        // Every length write gets a short length word.
        if (a.reg_addr[4:2] == REG_RD_LEN || a.reg_addr[4:2] == REG_WR_LEN) begin
          a.write_value = pick_length();
        end
      end else begin
        a.kind = KindUnused;
      end
      queued_accesses.push_back(a);
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every access to be taken and every result to be checked.
    do @(negedge clk_i);
    while (queued_accesses.size() != 0 || s_axis_tvalid || predicted_responses.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);

    $display("Ran %0d accesses in %0d cycles, with %0d DMA beats moved,",
             accepted_count, cycle_count, beats_moved);
    $display("%0d transfers launched and %0d completed.", transfers_launched,
             transfers_done);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/cdrb_pkg.sv
rtl/cdrb_ctrl.sv
rtl/cdrb_datapath.sv
rtl/coprocessor_dma_register_block_unit.sv
sim/testbench.sv
